// ----- rtl/ppun_pkg.sv -----
package ppun_pkg;

	// Default geometry of a frame.
	localparam int FIELD_BITS_DEF = 10;
	localparam int READINGS_DEF   = 8;

	// The unpacker never holds more than this many leftover bits.
	localparam int HELD_MAX = 15;
	localparam int HELD_W   = 4;

	localparam int RAW_W  = 10;
	localparam int GAIN_W = 24;
	localparam int PROX_W = 17;
	localparam int CHAN_W = 3;

	// Channel numbering starts at this value and counts down, modulo eight.
	localparam int CHAN_BASE = 11;

	localparam logic [PROX_W-1:0] PROX_ONE = PROX_W'(65536);
	localparam int                ROUND_SHIFT = 8;

	localparam logic [RAW_W-1:0]  CUTOFF_RST    = RAW_W'(150);
	localparam logic [RAW_W-1:0]  FULL_SCALE_RST = RAW_W'(1000);
	localparam logic [RAW_W-1:0]  OFFSET_RST    = RAW_W'(100);
	localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(18641);

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CUTOFF     = 2'd0,
		CFG_FULL_SCALE = 2'd1,
		CFG_OFFSET     = 2'd2,
		CFG_GAIN       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [RAW_W-1:0]  raw_reading;
		logic [PROX_W-1:0] proximity;
		logic              last_reading;
	} out_t;

endpackage

// ----- rtl/packed_proximity_unpack_normalize_unit.sv -----
// A byte that completes a reading is held in the stage 1 register and then in the result
// register. Throughput: one byte per cycle while out_stall is low; the stage 1 register
// feeds one 10x24 multiplier that sits between the unpack stage and the result register.
// Reset clears the unpacker, the pipeline valid bits and loads the register defaults.
// A byte that does not complete a reading produces no transaction on the output.
module packed_proximity_unpack_normalize_unit #(
	parameter int FIELD_BITS         = ppun_pkg::FIELD_BITS_DEF,
	parameter int READINGS_PER_FRAME = ppun_pkg::READINGS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ppun_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ppun_pkg::out_t                      out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppun_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppun_pkg::GAIN_W-1:0]         cfg_data
);

	localparam int IDX_W  = (READINGS_PER_FRAME > 1) ? $clog2(READINGS_PER_FRAME) : 1;
	localparam int ACC_W  = ppun_pkg::HELD_MAX;
	localparam int BITS_W = ACC_W + 8;
	localparam int TOT_W  = ppun_pkg::HELD_W + 1;
	localparam int RAW_W  = ppun_pkg::RAW_W;
	localparam int GAIN_W = ppun_pkg::GAIN_W;
	localparam int PROX_W = ppun_pkg::PROX_W;
	localparam int PROD_W = RAW_W + GAIN_W + 1;

	// Configuration registers.
	logic [RAW_W-1:0]  cutoff_q;
	logic [RAW_W-1:0]  full_scale_q;
	logic [RAW_W-1:0]  offset_q;
	logic [GAIN_W-1:0] gain_q;

	// Unpacker state.
	logic [ACC_W-1:0]              acc_q;
	logic [ppun_pkg::HELD_W-1:0]   held_q;
	logic [IDX_W-1:0]              idx_q;

	// Stage 1: unpacked reading.
	logic                          valid_s1;
	logic [RAW_W-1:0]              raw_s1;
	logic [ppun_pkg::CHAN_W-1:0]   chan_s1;
	logic                          last_s1;

	// Stage 2: result register.
	logic                          valid_s2;
	ppun_pkg::out_t                res_s2;

	logic en_s1;
	logic en_s2;
	logic accept;

	assign en_s2     = !valid_s2 || !out_stall;
	assign en_s1     = !valid_s1 || en_s2;
	assign in_stall  = !en_s1;
	assign accept    = in_valid && en_s1;
	assign cfg_ready = 1'b1;

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// Unpack logic.
	logic [ACC_W-1:0]            acc_eff;
	logic [ppun_pkg::HELD_W-1:0] held_eff;
	logic [IDX_W-1:0]            idx_eff;
	logic [ACC_W-1:0]            held_mask;
	logic [BITS_W-1:0]           bits;
	logic [TOT_W-1:0]            total;
	logic                        emit;
	logic [TOT_W-1:0]            rest;
	logic [ppun_pkg::HELD_W-1:0] rest_cap;
	logic [BITS_W-1:0]           shifted;
	logic [BITS_W-1:0]           field_mask;
	logic [BITS_W-1:0]           field;
	logic [ACC_W-1:0]            keep_mask;
	logic [ACC_W-1:0]            total_mask;
	logic                        last;
	logic [ppun_pkg::CHAN_W-1:0] chan;

	always_comb begin
		acc_eff    = in_data.frame_start ? '0 : acc_q;
		held_eff   = in_data.frame_start ? '0 : held_q;
		idx_eff    = in_data.frame_start ? '0 : idx_q;
		held_mask  = ACC_W'((16'(1) << held_eff) - 16'(1));
		bits       = {acc_eff & held_mask, in_data.data_byte};
		total      = TOT_W'(held_eff) + TOT_W'(8);
		emit       = total >= TOT_W'(FIELD_BITS);
		rest       = total - TOT_W'(FIELD_BITS);
		rest_cap   = (rest > TOT_W'(ppun_pkg::HELD_MAX)) ?
			ppun_pkg::HELD_W'(ppun_pkg::HELD_MAX) : rest[ppun_pkg::HELD_W-1:0];
		shifted    = bits >> rest;
		field_mask = (BITS_W'(1) << FIELD_BITS) - BITS_W'(1);
		field      = shifted & field_mask;
		keep_mask  = ACC_W'((16'(1) << rest_cap) - 16'(1));
		total_mask = ACC_W'((16'(1) << total[ppun_pkg::HELD_W-1:0]) - 16'(1));
		last       = (IDX_W + 1)'({1'b0, idx_eff} + (IDX_W + 1)'(1)) >=
			(IDX_W + 1)'(READINGS_PER_FRAME);
		chan       = ppun_pkg::CHAN_W'(5'(ppun_pkg::CHAN_BASE) - 5'(idx_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
			idx_q  <= '0;
		end else if (accept) begin
			if (!emit) begin
				acc_q  <= bits[ACC_W-1:0] & total_mask;
				held_q <= total[ppun_pkg::HELD_W-1:0];
				idx_q  <= idx_eff;
			end else if (last) begin
				acc_q  <= '0;
				held_q <= '0;
				idx_q  <= '0;
			end else begin
				acc_q  <= bits[ACC_W-1:0] & keep_mask;
				held_q <= rest_cap;
				idx_q  <= idx_eff + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q     <= ppun_pkg::CUTOFF_RST;
			full_scale_q <= ppun_pkg::FULL_SCALE_RST;
			offset_q     <= ppun_pkg::OFFSET_RST;
			gain_q       <= ppun_pkg::GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (ppun_pkg::cfg_idx_t'(cfg_index))
				ppun_pkg::CFG_CUTOFF:     cutoff_q     <= cfg_data[RAW_W-1:0];
				ppun_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_data[RAW_W-1:0];
				ppun_pkg::CFG_OFFSET:     offset_q     <= cfg_data[RAW_W-1:0];
				ppun_pkg::CFG_GAIN:       gain_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			raw_s1  <= field[RAW_W-1:0];
			chan_s1 <= chan;
			last_s1 <= last;
		end
	end

	// Normalization: zero below the cutoff, offset, scale by the Q24 gain, round to nearest Q16, saturate.
	logic [RAW_W-1:0]  diff;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] rounded;
	logic [PROD_W-ppun_pkg::ROUND_SHIFT-1:0] scaled;
	logic [PROX_W-1:0] prox;

	always_comb begin
		diff    = raw_s1 - offset_q;
		prod    = PROD_W'(diff) * PROD_W'(gain_q);
		rounded = prod + PROD_W'(1 << (ppun_pkg::ROUND_SHIFT - 1));
		scaled  = rounded[PROD_W-1:ppun_pkg::ROUND_SHIFT];
		if (raw_s1 < cutoff_q) begin
			prox = '0;
		end else if (raw_s1 > full_scale_q) begin
			prox = ppun_pkg::PROX_ONE;
		end else if (raw_s1 < offset_q) begin
			prox = '0;
		end else if (scaled > (PROD_W - ppun_pkg::ROUND_SHIFT)'(ppun_pkg::PROX_ONE)) begin
			prox = ppun_pkg::PROX_ONE;
		end else begin
			prox = scaled[PROX_W-1:0];
		end
	end

	// Stage 2 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			res_s2.channel      <= chan_s1;
			res_s2.raw_reading  <= raw_s1;
			res_s2.proximity    <= prox;
			res_s2.last_reading <= last_s1;
		end
	end

endmodule

// ----- tb/packed_proximity_unpack_normalize_unit_test.sv -----
`timescale 1ns / 100ps

module packed_proximity_unpack_normalize_unit_test;
	import ppun_pkg::*;

	localparam int TIMEOUT_CYCLES = 400000;
	localparam int SETTINGS_PER_MODE = 4;
	localparam int BYTES_PER_SETTING = 71;
	localparam int DIRECTED_ROWS = 17;

	typedef enum bit {ROW_BYTE, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		cfg_idx_t    reg_idx;
		logic [23:0] value;
		logic        start;
		bit          typed;
		out_t        want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]    cfg_data = '0;

	// Register copies and unpacker state of the prediction.
	logic [RAW_W-1:0]  cutoff_lvl = CUTOFF_RST;
	logic [RAW_W-1:0]  full_lvl = FULL_SCALE_RST;
	logic [RAW_W-1:0]  offset_lvl = OFFSET_RST;
	logic [GAIN_W-1:0] gain_val = GAIN_RST;
	logic [15:0]       acc_bits = '0;
	int unsigned       held_bits = 0;
	int unsigned       reading_idx = 0;

	out_t pending_readings[$];
	int   fail_count = 0;
	int   in_idle_pct = 0;
	int   out_idle_pct = 0;

	// Rows with the typed flag carry their result typed in; the rest are checked against the prediction.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_BYTE, CFG_CUTOFF, 24'hFF, 1'b1, 1'b0, '0},
		'{ROW_BYTE, CFG_CUTOFF, 24'hC0, 1'b0, 1'b1, {3'd3, 10'd1023, PROX_ONE, 1'b0}},
		'{ROW_BYTE, CFG_CUTOFF, 24'h02, 1'b0, 1'b1, {3'd2, 10'd0, 17'd0, 1'b0}},
		'{ROW_BYTE, CFG_CUTOFF, 24'h58, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_CUTOFF, 24'h95, 1'b0, 1'b1, {3'd0, 10'd149, 17'd0, 1'b0}},
		'{ROW_BYTE, CFG_CUTOFF, 24'hFA, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_CUTOFF, 24'h3E, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_CUTOFF, 24'h91, 1'b0, 1'b1, {3'd6, 10'd1001, PROX_ONE, 1'b0}},
		'{ROW_BYTE, CFG_CUTOFF, 24'hE3, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_CUTOFF, 24'hFF, 1'b0, 1'b1, {3'd4, 10'd1023, PROX_ONE, 1'b1}},
		// A new frame begins without a frame start after the last reading.
		'{ROW_BYTE, CFG_CUTOFF, 24'h5A, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_CUTOFF, 24'hA5, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_OFFSET, 24'd400, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_GAIN, 24'hFFFFFF, 1'b0, 1'b0, '0},
		// Frame start in the middle of a frame drops the held bits.
		'{ROW_BYTE, CFG_CUTOFF, 24'h32, 1'b1, 1'b0, '0},
		'{ROW_BYTE, CFG_CUTOFF, 24'h3E, 1'b0, 1'b1, {3'd3, 10'd200, 17'd0, 1'b0}},
		'{ROW_BYTE, CFG_CUTOFF, 24'h80, 1'b0, 1'b1, {3'd2, 10'd1000, PROX_ONE, 1'b0}}
	};

	packed_proximity_unpack_normalize_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned low_bits(input int unsigned n);
		return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
	endfunction

	function automatic logic [PROX_W-1:0] scale_proximity(input logic [RAW_W-1:0] raw);
		longint unsigned prod;
		if (raw < cutoff_lvl) return '0;
		if (raw > full_lvl) return PROX_ONE;
		if (raw < offset_lvl) return '0;
		prod = raw - offset_lvl;
		prod = prod * gain_val;
		prod = (prod + 128) >> ROUND_SHIFT;
		if (prod > 65536) prod = 65536;
		return PROX_W'(prod);
	endfunction

	function automatic bit unpack_and_scale(input in_t item, output out_t res);
		int unsigned merged;
		int unsigned total;
		int unsigned rest;
		int unsigned raw;
		bit          last;
		res = '0;
		if (item.frame_start) begin
			acc_bits = '0;
			held_bits = 0;
			reading_idx = 0;
		end
		merged = ((acc_bits & low_bits(held_bits)) << 8) | item.data_byte;
		total = held_bits + 8;
		if (total < FIELD_BITS_DEF) begin
			acc_bits = 16'(merged & low_bits(total));
			held_bits = total;
			return 1'b0;
		end
		rest = total - FIELD_BITS_DEF;
		raw = (merged >> rest) & low_bits(FIELD_BITS_DEF);
		if (rest > HELD_MAX) rest = HELD_MAX;
		last = (reading_idx + 1 >= READINGS_DEF);
		res.channel = CHAN_W'(CHAN_BASE - reading_idx);
		res.raw_reading = RAW_W'(raw);
		res.proximity = scale_proximity(RAW_W'(raw));
		res.last_reading = last;
		if (last) begin
			acc_bits = '0;
			held_bits = 0;
			reading_idx = 0;
		end else begin
			acc_bits = 16'(merged & low_bits(rest));
			held_bits = rest;
			reading_idx = reading_idx + 1;
		end
		return 1'b1;
	endfunction

	function automatic void apply_register(input cfg_idx_t idx, input logic [GAIN_W-1:0] value);
		case (idx)
			CFG_CUTOFF: begin
				cutoff_lvl = value[RAW_W-1:0];
			end
			CFG_FULL_SCALE: begin
				full_lvl = value[RAW_W-1:0];
			end
			CFG_OFFSET: begin
				offset_lvl = value[RAW_W-1:0];
			end
			CFG_GAIN: begin
				gain_val = value;
			end
			default: begin
			end
		endcase
	endfunction

	// Readings are drawn around the current thresholds three times in eight, else at the extremes or at random.
	function automatic logic [RAW_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return RAW_W'(cutoff_lvl + $urandom_range(0, 2) - 1);
			1: return RAW_W'(full_lvl + $urandom_range(0, 2) - 1);
			2: return RAW_W'(offset_lvl + $urandom_range(0, 2) - 1);
			3: return $urandom_range(0, 1) ? RAW_W'(1023) : RAW_W'(0);
			default: return RAW_W'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
	endtask

	task automatic send_byte(input in_t item, input bit typed, input out_t want);
		out_t res;
		logic stalled;
		if (unpack_and_scale(item, res)) pending_readings.push_back(typed ? want : res);
		if ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [GAIN_W-1:0] value);
		logic rdy;
		drain_results();
		// Let a byte that completes no reading clear the pipeline as well.
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
		apply_register(idx, value);
	endtask

	task automatic apply_setting(input int setting);
		logic [RAW_W-1:0]  cut;
		logic [RAW_W-1:0]  full;
		logic [RAW_W-1:0]  off;
		logic [GAIN_W-1:0] gain;
		int unsigned       span;
		case (setting % 6)
			0: begin
				off = RAW_W'($urandom_range(0, 300));
				full = RAW_W'($urandom_range(off + 100, 1023));
				cut = RAW_W'($urandom_range(off, off + 100));
				span = full - off;
				gain = GAIN_W'((((32'd1 << 25) / span) + 1) >> 1);
			end
			1: begin
				cut = '0;
				full = '0;
				off = '0;
				gain = '0;
			end
			2: begin
				cut = '1;
				full = '1;
				off = '1;
				gain = '1;
			end
			3: begin
				// Offset above the cutoff, so readings in between saturate to zero.
				cut = RAW_W'($urandom_range(0, 200));
				off = RAW_W'($urandom_range(400, 700));
				full = RAW_W'($urandom_range(800, 1023));
				gain = GAIN_W'($urandom_range(0, 24'hFFFFFF));
			end
			4: begin
				cut = RAW_W'($urandom_range(0, 1023));
				full = RAW_W'($urandom_range(0, 1023));
				off = RAW_W'($urandom_range(0, 1023));
				gain = GAIN_W'($urandom_range(0, 24'hFFFFFF));
			end
			default: begin
				cut = CUTOFF_RST;
				full = FULL_SCALE_RST;
				off = OFFSET_RST;
				gain = GAIN_RST;
			end
		endcase
		// Upper data bits of the 10-bit registers are junk that must be ignored.
		write_register(CFG_CUTOFF, {14'($urandom_range(0, 16383)), cut});
		write_register(CFG_FULL_SCALE, {14'($urandom_range(0, 16383)), full});
		write_register(CFG_OFFSET, {14'($urandom_range(0, 16383)), off});
		write_register(CFG_GAIN, gain);
	endtask

	task automatic run_traffic(input int budget);
		logic [79:0] stream;
		int          sent;
		int          kind;
		int          len;
		int          k;
		bit          start;
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(0, 9);
			for (k = 0; k < READINGS_DEF; k++) stream[79 - 10 * k -: 10] = pick_level();
			if (kind == 7) len = $urandom_range(1, 9);
			else if (kind == 9) len = $urandom_range(1, 12);
			else len = 10;
			for (k = 0; k < len; k++) begin
				if (kind == 9) start = ($urandom_range(0, 5) == 0);
				else start = (kind != 8) && (k == 0);
				if (kind == 9 || k >= 10) begin
					send_byte('{data_byte: 8'($urandom_range(0, 255)), frame_start: start},
						1'b0, '0);
				end else begin
					send_byte('{data_byte: stream[79 - 8 * k -: 8], frame_start: start},
						1'b0, '0);
				end
			end
			sent += len;
			if ($urandom_range(0, 19) == 0) drain_results();
		end
	endtask

	task automatic check_result(input out_t seen);
		out_t want;
		if (pending_readings.size() == 0) begin
			if (fail_count < 10) begin
				$display("unexpected result: ch=%0d raw=%0d prox=%0d last=%0d",
					seen.channel, seen.raw_reading, seen.proximity, seen.last_reading);
			end
			fail_count++;
		end else begin
			want = pending_readings.pop_front();
			if (seen.channel !== want.channel || seen.raw_reading !== want.raw_reading ||
				seen.proximity !== want.proximity ||
				seen.last_reading !== want.last_reading) begin
				if (fail_count < 10) begin
					$display("mismatch: expected ch=%0d raw=%0d prox=%0d last=%0d, %s",
						want.channel, want.raw_reading, want.proximity, want.last_reading,
						$sformatf("got ch=%0d raw=%0d prox=%0d last=%0d", seen.channel,
						seen.raw_reading, seen.proximity, seen.last_reading));
				end
				fail_count++;
			end
		end
	endtask

	// Result side: a transaction is sampled at the falling edge before the rising edge that takes it.
	initial begin
		logic took;
		out_t seen;
		forever begin
			@(negedge clk);
			took = arst_n && (out_valid === 1'b1) && !out_stall;
			seen = out_data;
			@(posedge clk);
			if (took) check_result(seen);
			out_stall <= ($urandom_range(0, 99) < out_idle_pct);
		end
	end

	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int mode;
		int s;
		int r;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_idle_pct = 9;
		out_idle_pct = 74;
		for (r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_REG) begin
				write_register(directed_rows[r].reg_idx, directed_rows[r].value);
			end else begin
				send_byte('{data_byte: directed_rows[r].value[7:0],
					frame_start: directed_rows[r].start},
					directed_rows[r].typed, directed_rows[r].want);
			end
		end

		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					in_idle_pct = 9;
					out_idle_pct = 74;
				end
				1: begin
					in_idle_pct = 74;
					out_idle_pct = 9;
				end
				default: begin
					in_idle_pct = 0;
					out_idle_pct = 0;
				end
			endcase
			for (s = 0; s < SETTINGS_PER_MODE; s++) begin
				apply_setting(mode * SETTINGS_PER_MODE + s);
				run_traffic(BYTES_PER_SETTING);
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ppun_pkg.sv
rtl/packed_proximity_unpack_normalize_unit.sv
tb/packed_proximity_unpack_normalize_unit_test.sv
